### src/fan_cal_pkg.sv
package fan_cal_pkg;

  // command codes (s_tuser)
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_ABORT = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // phase codes as reported in the result
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_STOP1 = 2'd1;
  localparam logic [1:0] PH_START = 2'd2;
  localparam logic [1:0] PH_STOP2 = 2'd3;

  localparam logic [7:0]  DUTY_FULL   = 8'd255;
  localparam logic [7:0]  STOP_MARGIN = 8'd5;
  localparam logic [7:0]  START_STEP  = 8'd2;
  localparam logic [10:0] WAIT_NONE   = 11'd0;
  localparam logic [10:0] WAIT_STOP1  = 11'd2000;
  localparam logic [10:0] WAIT_START  = 11'd500;
  localparam logic [10:0] WAIT_STOP2  = 11'd1000;

  // x / 10 for x < 2^16 is (x * 52429) >> 19
  localparam logic [15:0] RECIP_TEN = 16'd52429;

  typedef struct packed {
    logic [1:0] phase;
    logic [7:0] duty;
    logic [7:0] min_start;
    logic [7:0] min_stop;
    logic       testing;
    logic       manual;
  } cal_state_t;

  typedef struct packed {
    logic [10:0] wait_ms;
    logic [7:0]  min_stop;
    logic [7:0]  min_start;
    logic [1:0]  phase;
    logic        testing;
    logic        manual_mode;
    logic [7:0]  pwm_duty;
    logic        finished;
  } cal_result_t;

  // min(floor(9*d/10), d-5), floored at zero
  function automatic logic [7:0] lower_fast(input logic [7:0] d);
    logic [11:0] nine_d;
    logic [27:0] prod;
    logic [7:0]  scaled;
    logic [7:0]  minus;
    nine_d = {d, 3'b000} + {4'b0000, d};
    prod   = {16'd0, nine_d} * {12'd0, RECIP_TEN};
    scaled = prod[26:19];
    minus  = (d >= STOP_MARGIN) ? (d - STOP_MARGIN) : 8'd0;
    return (scaled < minus) ? scaled : minus;
  endfunction

endpackage

### src/fan_threshold_calibration.sv
// Fan threshold calibration sequencer.
// Input channel (s_*): one transaction per event. s_tuser carries the command
// (start, abort, timer tick), s_tdata the measured rpm used on a tick.
// Output channel (m_*): exactly one result transaction per input event, with
// the commanded duty, mode/testing flags, phase, recorded min_start and
// min_stop, and the wait in ms asked for before the next tick (0 = none).
// m_tlast is high on the result of the tick that completes calibration.
// The result is registered: result register, or skid entry while one waits.
// Throughput: one event per cycle while s_tready is high; the next-state logic
// is one short pass (a 12x16 reciprocal multiply divides by ten in phase one).
// Calibration state updates at input acceptance, so ordering is preserved.
// A two-entry output stage (result register plus skid) lets one more event
// be taken while a result waits; s_tready drops only when both are full.
// Reset (rst, synchronous): phase idle, duty, min_start and min_stop 255,
// testing and manual mode cleared, output channel empty.
module fan_threshold_calibration (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // [15:0] rpm
  input  logic [1:0]  s_tuser,  // [1:0] cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,  // [7:0] pwm_duty, [8] manual_mode, [9] testing,
                                // [11:10] phase, [19:12] min_start,
                                // [27:20] min_stop, [38:28] wait_ms, [39] zero
  output logic        m_tlast   // finished
);

  fan_cal_pkg::cal_state_t  state;
  fan_cal_pkg::cal_state_t  state_next;
  fan_cal_pkg::cal_result_t step_res;
  fan_cal_pkg::cal_result_t out_res;
  logic                     accept;
  logic                     skid_full;

  assign accept = s_tvalid && s_tready;

  // Next state and result from the current state and the incoming event
  fan_cal_step u_step (
    .cur (state),
    .cmd (s_tuser),
    .rpm (s_tdata),
    .nxt (state_next),
    .res (step_res)
  );

  // Calibration state registers; they move only on an accepted event
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase     <= fan_cal_pkg::PH_IDLE;
      state.duty      <= fan_cal_pkg::DUTY_FULL;
      state.min_start <= fan_cal_pkg::DUTY_FULL;
      state.min_stop  <= fan_cal_pkg::DUTY_FULL;
      state.testing   <= 1'b0;
      state.manual    <= 1'b0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  // Result register with skid stage
  fan_cal_out u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (step_res),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_res),
    .skid_full (skid_full)
  );

  assign m_tdata = {1'b0, out_res.wait_ms, out_res.min_stop, out_res.min_start,
                    out_res.phase, out_res.testing, out_res.manual_mode,
                    out_res.pwm_duty};
  assign m_tlast = out_res.finished;

`ifndef SYNTHESIS
  // testing flag and non-idle phase always move together
  a_testing_phase: assert property (@(posedge clk) disable iff (rst)
    state.testing == (state.phase != fan_cal_pkg::PH_IDLE))
    else $error("testing flag disagrees with phase");

  // a running calibration has manual mode set
  a_manual_when_testing: assert property (@(posedge clk) disable iff (rst)
    state.testing |-> state.manual)
    else $error("calibration running without manual mode");

  // skid entry only holds data behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_full |-> m_tvalid)
    else $error("skid entry full with empty result register");

  // the finishing result reports idle and not testing
  a_finish_idle: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tdata[11:10] == fan_cal_pkg::PH_IDLE && !m_tdata[9]))
    else $error("finished result not idle");
`endif

endmodule

### src/fan_cal_step.sv
module fan_cal_step (
  input  fan_cal_pkg::cal_state_t  cur,
  input  logic [1:0]               cmd,
  input  logic [15:0]              rpm,
  output fan_cal_pkg::cal_state_t  nxt,
  output fan_cal_pkg::cal_result_t res
);

  logic        spinning;
  logic [10:0] wait_val;
  logic        done;
  logic [8:0]  duty_up;
  logic [8:0]  duty_margin;

  assign spinning    = (rpm != 16'd0);
  assign duty_up     = {1'b0, cur.duty} + {1'b0, fan_cal_pkg::START_STEP};
  assign duty_margin = {1'b0, cur.duty} + {1'b0, fan_cal_pkg::STOP_MARGIN};

  always_comb begin
    nxt      = cur;
    wait_val = fan_cal_pkg::WAIT_NONE;
    done     = 1'b0;
    unique case (cmd)
      fan_cal_pkg::CMD_START: begin
        nxt.testing = 1'b1;
        nxt.phase   = fan_cal_pkg::PH_STOP1;
        nxt.manual  = 1'b1;
        nxt.duty    = fan_cal_pkg::DUTY_FULL;
        wait_val    = fan_cal_pkg::WAIT_STOP1;
      end
      fan_cal_pkg::CMD_ABORT: begin
        nxt.duty    = fan_cal_pkg::DUTY_FULL;
        nxt.testing = 1'b0;
        nxt.phase   = fan_cal_pkg::PH_IDLE;
      end
      fan_cal_pkg::CMD_TICK: begin
        unique case (cur.phase)
          fan_cal_pkg::PH_STOP1: begin
            if (spinning) begin
              nxt.duty = fan_cal_pkg::lower_fast(cur.duty);
              wait_val = fan_cal_pkg::WAIT_STOP1;
            end else begin
              nxt.phase = fan_cal_pkg::PH_START;
              wait_val  = fan_cal_pkg::WAIT_START;
            end
          end
          fan_cal_pkg::PH_START: begin
            if (!spinning) begin
              nxt.duty = duty_up[8] ? fan_cal_pkg::DUTY_FULL : duty_up[7:0];
              wait_val = fan_cal_pkg::WAIT_START;
            end else begin
              nxt.phase     = fan_cal_pkg::PH_STOP2;
              nxt.min_start = cur.duty;
              wait_val      = fan_cal_pkg::WAIT_STOP2;
            end
          end
          fan_cal_pkg::PH_STOP2: begin
            if (spinning) begin
              nxt.duty = (cur.duty != 8'd0) ? (cur.duty - 8'd1) : 8'd0;
              wait_val = fan_cal_pkg::WAIT_STOP2;
            end else begin
              nxt.phase    = fan_cal_pkg::PH_IDLE;
              nxt.testing  = 1'b0;
              nxt.min_stop = duty_margin[8] ? fan_cal_pkg::DUTY_FULL : duty_margin[7:0];
              done         = 1'b1;
            end
          end
          default: begin
            nxt.testing = 1'b0;
          end
        endcase
      end
      default: begin
        // unused command: report state only
      end
    endcase
  end

  always_comb begin
    res.wait_ms     = wait_val;
    res.min_stop    = nxt.min_stop;
    res.min_start   = nxt.min_start;
    res.phase       = nxt.phase;
    res.testing     = nxt.testing;
    res.manual_mode = nxt.manual;
    res.pwm_duty    = nxt.duty;
    res.finished    = done;
  end

endmodule

### src/fan_cal_out.sv
module fan_cal_out (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  fan_cal_pkg::cal_result_t in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output fan_cal_pkg::cal_result_t out_data,
  output logic                     skid_full
);

  fan_cal_pkg::cal_result_t skid_data;
  logic                     skid_valid;
  logic                     take;

  assign in_ready  = !skid_valid;
  assign take      = in_valid && in_ready;
  assign skid_full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take) begin
      if (out_valid && !out_ready) begin
        skid_data  <= in_data;
        skid_valid <= 1'b1;
      end else begin
        out_data  <= in_data;
        out_valid <= 1'b1;
      end
    end else if (out_ready) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### tb/fan_cal_checker.sv
`timescale 1ns / 100ps

// Watches both channels, models the calibration sequencer and scores results.
module fan_cal_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,
  input  logic        m_tlast,
  output int          errors,
  output int          pending
);

  // modeled calibration state
  logic [1:0]  cal_phase;
  logic [7:0]  duty;
  logic [7:0]  start_duty;
  logic [7:0]  stop_duty;
  logic        testing_q;
  logic        manual_q;

  fan_cal_pkg::cal_result_t expected_results[$];

  // phase one step: min(floor(9d/10), d-5), not below zero
  function automatic logic [7:0] fast_drop(input logic [7:0] d);
    int tenth;
    int less;
    tenth = (9 * int'(d)) / 10;
    less  = (d >= fan_cal_pkg::STOP_MARGIN) ?
            int'(d) - int'(fan_cal_pkg::STOP_MARGIN) : 0;
    return (tenth < less) ? 8'(tenth) : 8'(less);
  endfunction

  task automatic predict_event(input logic [1:0] cmd, input logic [15:0] rpm);
    fan_cal_pkg::cal_result_t r;
    logic [10:0] wait_ms;
    logic        done;
    wait_ms = fan_cal_pkg::WAIT_NONE;
    done    = 1'b0;
    case (cmd)
      fan_cal_pkg::CMD_START: begin
        testing_q = 1'b1;
        manual_q  = 1'b1;
        cal_phase = fan_cal_pkg::PH_STOP1;
        duty      = fan_cal_pkg::DUTY_FULL;
        wait_ms   = fan_cal_pkg::WAIT_STOP1;
      end
      fan_cal_pkg::CMD_ABORT: begin
        duty      = fan_cal_pkg::DUTY_FULL;
        testing_q = 1'b0;
        cal_phase = fan_cal_pkg::PH_IDLE;
      end
      fan_cal_pkg::CMD_TICK: begin
        case (cal_phase)
          fan_cal_pkg::PH_STOP1: begin
            if (rpm != 16'd0) begin
              duty    = fast_drop(duty);
              wait_ms = fan_cal_pkg::WAIT_STOP1;
            end else begin
              cal_phase = fan_cal_pkg::PH_START;
              wait_ms   = fan_cal_pkg::WAIT_START;
            end
          end
          fan_cal_pkg::PH_START: begin
            if (rpm == 16'd0) begin
              duty    = (int'(duty) + int'(fan_cal_pkg::START_STEP) >
                         int'(fan_cal_pkg::DUTY_FULL)) ?
                        fan_cal_pkg::DUTY_FULL : duty + fan_cal_pkg::START_STEP;
              wait_ms = fan_cal_pkg::WAIT_START;
            end else begin
              cal_phase  = fan_cal_pkg::PH_STOP2;
              start_duty = duty;
              wait_ms    = fan_cal_pkg::WAIT_STOP2;
            end
          end
          fan_cal_pkg::PH_STOP2: begin
            if (rpm != 16'd0) begin
              duty    = (duty != 8'd0) ? duty - 8'd1 : 8'd0;
              wait_ms = fan_cal_pkg::WAIT_STOP2;
            end else begin
              cal_phase = fan_cal_pkg::PH_IDLE;
              testing_q = 1'b0;
              stop_duty = (int'(duty) + int'(fan_cal_pkg::STOP_MARGIN) >
                           int'(fan_cal_pkg::DUTY_FULL)) ?
                          fan_cal_pkg::DUTY_FULL : duty + fan_cal_pkg::STOP_MARGIN;
              done      = 1'b1;
            end
          end
          default: testing_q = 1'b0;  // tick while idle
        endcase
      end
      default: ;  // unused command: report state only
    endcase
    r.pwm_duty    = duty;
    r.manual_mode = manual_q;
    r.testing     = testing_q;
    r.phase       = cal_phase;
    r.min_start   = start_duty;
    r.min_stop    = stop_duty;
    r.wait_ms     = wait_ms;
    r.finished    = done;
    expected_results.push_back(r);
  endtask

  task automatic compare_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
    end
  endtask

  task automatic check_result();
    fan_cal_pkg::cal_result_t e;
    if (expected_results.size() == 0) begin
      errors++;
      $display("%0t: unexpected result transaction, expected none, actual 0x%010h",
               $time, m_tdata);
    end else begin
      e = expected_results.pop_front();
      compare_field("pwm_duty", int'(e.pwm_duty), int'(m_tdata[7:0]));
      compare_field("manual_mode", int'(e.manual_mode), int'(m_tdata[8]));
      compare_field("testing", int'(e.testing), int'(m_tdata[9]));
      compare_field("phase", int'(e.phase), int'(m_tdata[11:10]));
      compare_field("min_start", int'(e.min_start), int'(m_tdata[19:12]));
      compare_field("min_stop", int'(e.min_stop), int'(m_tdata[27:20]));
      compare_field("wait_ms", int'(e.wait_ms), int'(m_tdata[38:28]));
      compare_field("tdata pad", 0, int'(m_tdata[39]));
      compare_field("finished", int'(e.finished), int'(m_tlast));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cal_phase  = fan_cal_pkg::PH_IDLE;
      duty       = fan_cal_pkg::DUTY_FULL;
      start_duty = fan_cal_pkg::DUTY_FULL;
      stop_duty  = fan_cal_pkg::DUTY_FULL;
      testing_q  = 1'b0;
      manual_q   = 1'b0;
      expected_results.delete();
    end else begin
      if (m_tvalid && m_tready) check_result();
      if (s_tvalid && s_tready) predict_event(s_tuser, s_tdata);
    end
    pending = expected_results.size();
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the fan calibration sequencer; scoring lives in
// fan_cal_checker.
module tb_top;

  localparam logic [1:0] CMD_UNUSED = 2'd3;  // no defined meaning
  localparam int RANDOM_EVENTS = 1750;
  localparam int CYCLE_LIMIT   = 400000;     // far above the slowest legal run
  localparam int STALL_CYCLES  = 200;        // long receiver hold-off
  localparam int DRAIN_CYCLES  = 8;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = 16'd0;   // [15:0] rpm
  logic [1:0]  s_tuser = 2'd0;    // [1:0] cmd
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;           // [7:0] pwm_duty, [8] manual_mode, [9] testing,
                                  // [11:10] phase, [19:12] min_start,
                                  // [27:20] min_stop, [38:28] wait_ms, [39] zero
  logic        m_tlast;           // finished

  int error_count;
  int pending_count;

  // idle percentages for each side, changed per stimulus phase
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  // set once by stimulus to ask the receiver for its long hold-off
  logic stall_req = 1'b0;

  int sent_count = 0;
  int cycle_count = 0;

  fan_threshold_calibration DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  fan_cal_checker u_checker (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .errors   (error_count),
    .pending  (pending_count)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // watchdog: the whole run must end well before the limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // Receiver: random backpressure, plus one long hold-off on request so the
  // output stage fills and s_tready drops while the sender keeps offering.
  initial begin
    bit stall_done;
    stall_done = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_req && !stall_done) begin
        m_tready = 1'b0;
        repeat (STALL_CYCLES) @(negedge clk);
        stall_done = 1'b1;
      end
      m_tready = ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // One input transaction. Starts at a falling edge, may idle first, and
  // returns at the rising edge where the transaction is taken.
  task automatic send_event(input logic [1:0] cmd, input logic [15:0] rpm);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = rpm;
    s_tuser  = cmd;
    do @(posedge clk); while (!s_tready);
    sent_count++;
  endtask

  // a nonzero fan speed, with the extremes weighted up
  function automatic logic [15:0] spin_rpm();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 16'd1;
    if (pick == 1) return 16'hFFFF;
    return 16'($urandom_range(1, 16'hFFFF));
  endfunction

  // full calibration: n_drop spinning ticks in phase one, n_rise still ticks
  // in phase two, n_fall spinning ticks in phase three
  task automatic run_calibration(input int n_drop, input int n_rise, input int n_fall);
    send_event(fan_cal_pkg::CMD_START, 16'($urandom()));
    repeat (n_drop) send_event(fan_cal_pkg::CMD_TICK, spin_rpm());
    send_event(fan_cal_pkg::CMD_TICK, 16'd0);
    repeat (n_rise) send_event(fan_cal_pkg::CMD_TICK, 16'd0);
    send_event(fan_cal_pkg::CMD_TICK, spin_rpm());
    repeat (n_fall) send_event(fan_cal_pkg::CMD_TICK, spin_rpm());
    send_event(fan_cal_pkg::CMD_TICK, 16'd0);
  endtask

  initial begin
    int pick;
    int n_drop;
    int n_rise;
    int n_fall;
    int n_evt;
    logic [15:0] rpm;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed part runs with both sides idling like the first random phase
    send_idle_pct = 34;
    recv_idle_pct = 79;

    // idle corner cases: tick, unused command, abort
    send_event(fan_cal_pkg::CMD_TICK, 16'd0);
    send_event(CMD_UNUSED, 16'hFFFF);
    send_event(fan_cal_pkg::CMD_ABORT, 16'hFFFF);
    // short full calibration
    send_event(fan_cal_pkg::CMD_START, 16'd0);
    send_event(fan_cal_pkg::CMD_TICK, 16'hFFFF);
    send_event(fan_cal_pkg::CMD_TICK, 16'd1);
    send_event(fan_cal_pkg::CMD_TICK, 16'd0);
    send_event(fan_cal_pkg::CMD_TICK, 16'd0);
    send_event(fan_cal_pkg::CMD_TICK, 16'hFFFF);
    send_event(fan_cal_pkg::CMD_TICK, 16'd1);
    send_event(fan_cal_pkg::CMD_TICK, 16'd0);
    send_event(fan_cal_pkg::CMD_TICK, 16'hFFFF);   // tick after completion
    // fan stops at full duty: duty and min_stop saturate at 255
    send_event(fan_cal_pkg::CMD_START, 16'hFFFF);
    send_event(fan_cal_pkg::CMD_TICK, 16'd0);
    send_event(fan_cal_pkg::CMD_TICK, 16'd0);
    send_event(fan_cal_pkg::CMD_TICK, 16'd1);
    send_event(fan_cal_pkg::CMD_TICK, 16'd0);
    // restart while running, unused command and abort mid-run
    send_event(fan_cal_pkg::CMD_START, 16'd0);
    send_event(fan_cal_pkg::CMD_TICK, 16'd100);
    send_event(fan_cal_pkg::CMD_START, 16'hFFFF);
    send_event(fan_cal_pkg::CMD_TICK, 16'd0);
    send_event(CMD_UNUSED, 16'd0);
    send_event(fan_cal_pkg::CMD_ABORT, 16'd0);
    send_event(fan_cal_pkg::CMD_TICK, 16'd0);

    sent_count = 0;
    while (sent_count < RANDOM_EVENTS) begin
      // three idling phases; long hold-off at the start of the last one
      if (sent_count < RANDOM_EVENTS / 3) begin
        send_idle_pct = 34;
        recv_idle_pct = 79;
      end else if (sent_count < (2 * RANDOM_EVENTS) / 3) begin
        send_idle_pct = 79;
        recv_idle_pct = 34;
      end else if (send_idle_pct != 0) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_req     = 1'b1;
      end

      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        // well-formed run, occasionally long enough to hit the duty floors
        n_drop = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 12);
        n_rise = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 140) : $urandom_range(0, 4);
        n_fall = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
        run_calibration(n_drop, n_rise, n_fall);
      end else if (pick < 85) begin
        // broken run: random ticks, then abort or restart
        send_event(fan_cal_pkg::CMD_START, 16'($urandom()));
        n_evt = $urandom_range(1, 20);
        repeat (n_evt) begin
          rpm = $urandom_range(0, 1) ? 16'd0 : spin_rpm();
          send_event(fan_cal_pkg::CMD_TICK, rpm);
        end
        send_event($urandom_range(0, 1) ? fan_cal_pkg::CMD_ABORT : fan_cal_pkg::CMD_START,
                   16'($urandom()));
      end else begin
        // noise: any command, any speed
        n_evt = $urandom_range(1, 10);
        repeat (n_evt) begin
          rpm = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom());
          send_event(2'($urandom_range(0, 3)), rpm);
        end
      end
    end

    @(negedge clk);
    s_tvalid = 1'b0;

    wait (pending_count == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0 && pending_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
